// ===== hdl/edf_pkg.sv =====
// Shared types and constants for the earliest-deadline-first selector.
// Depends on nothing; imported by every module under hdl.
`timescale 1ns / 1ps

package edf_pkg;

    localparam int NUM_TASKS_DEF = 4;
    localparam int NUM_SLOTS     = 4;
    localparam int TASK_W        = 2;
    localparam int CNT_W         = 8;
    localparam int CFG_IDX_W     = 8;

    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DEADLINE_RST [NUM_SLOTS] = '{8'd15, 8'd20, 8'd35, 8'd40};

    // operation codes carried on s_tuser
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic ready;      // sequencer can take a transaction
        logic scan_step;  // one counter goes through the shared unit
        logic load_out;   // result register loads this cycle
    } ctrl_t;

endpackage

// ===== hdl/edf_scan_unit.sv =====
// Shared decrement and compare unit: one task counter per cycle while step is high.
// Keeps the running minimum and its index. Uses edf_pkg.
`timescale 1ns / 1ps

module edf_scan_unit #(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF,
    parameter int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              step,
    input  logic [IDX_W-1:0]  idx,
    input  edf_pkg::cnt_t     value,
    output edf_pkg::cnt_t     dec_value,
    output logic              active,
    output logic              found,
    output logic [IDX_W-1:0]  best
);
    import edf_pkg::*;

    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_reg, best_next;
    cnt_t             best_val_reg, best_val_next;
    logic             take;

    assign active    = (value != '0);
    assign dec_value = value - cnt_t'(1);
    // strict less-than keeps the lowest index on a tie
    assign take      = step && active && (!found_reg || (dec_value < best_val_reg));

    always_comb begin
        found_next    = found_reg;
        best_next     = best_reg;
        best_val_next = best_val_reg;
        if (clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next    = 1'b1;
            best_next     = idx;
            best_val_next = dec_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
    end

    assign found = found_reg;
    assign best  = best_reg;

endmodule

// ===== hdl/edf_seq.sv =====
// Sequencer: idle, walk the task counters on a tick, then deliver the result.
// Drives the shared scan unit through a ctrl_t bundle. Uses edf_pkg.
`timescale 1ns / 1ps

module edf_seq #(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF,
    parameter int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              op,
    input  logic              out_free,
    output edf_pkg::ctrl_t    ctrl,
    output logic [IDX_W-1:0]  scan_idx
);
    import edf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (op == OP_TICK) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE: ctrl.ready     = 1'b1;
            ST_SCAN: ctrl.scan_step = 1'b1;
            ST_DONE: ctrl.load_out  = out_free;
            default: ctrl           = '0;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (accept) begin
            idx_next = '0;
        end else if (state_reg == ST_SCAN && idx_reg != LAST_IDX) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign scan_idx = idx_reg;

endmodule

// ===== hdl/edf_deadline_selector_top.sv =====
// Top level of the earliest-deadline-first selector: counters, deadline
// registers, result register. Uses edf_pkg, edf_seq and edf_scan_unit.
// A tick passes through the scan and done states, a release only through done,
// before m_tvalid rises; the shared scan unit visits one task counter a cycle.
// A new item is accepted only in idle, once the last result has been loaded.
// Reset (aresetn low, synchronous): counters zero, no task chosen, deadlines
// back to 15/20/35/40, no result pending.
`timescale 1ns / 1ps

module edf_deadline_selector_top #(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [edf_pkg::CNT_W-1:0]    cfg_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [1:0] task_index, rest zero
    input  logic [0:0]                   s_tuser,  // [0] operation
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] chosen_task, [2] chosen_valid, [3] switched,
    // [5:4] demoted_task, [6] demoted_valid, [7] zero
    output logic [7:0]                   m_tdata
);
    import edf_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    ctrl_t            ctrl;
    logic [IDX_W-1:0] scan_idx;
    logic             accept;
    logic             out_free;
    logic [TASK_W-1:0] rel_task;
    logic             rel_ok;

    cnt_t             deadline_reg [NUM_SLOTS];
    cnt_t             remaining_reg [NUM_TASKS];

    cnt_t             dec_value;
    logic             active;
    logic             found;
    logic [IDX_W-1:0] best;
    logic [TASK_W-1:0] best_task;

    logic              cur_valid_reg;
    logic [TASK_W-1:0] cur_task_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;

    logic              sw;

    assign cfg_ready = 1'b1;
    assign s_tready  = ctrl.ready;
    assign accept    = s_tvalid && ctrl.ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign rel_task  = s_tdata[TASK_W-1:0];
    assign rel_ok    = ({1'b0, rel_task} < (TASK_W+1)'(NUM_TASKS));

    edf_seq #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .op       (s_tuser[0]),
        .out_free (out_free),
        .ctrl     (ctrl),
        .scan_idx (scan_idx)
    );

    edf_scan_unit #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (accept),
        .step      (ctrl.scan_step),
        .idx       (scan_idx),
        .value     (remaining_reg[scan_idx]),
        .dec_value (dec_value),
        .active    (active),
        .found     (found),
        .best      (best)
    );

    // configuration registers; indexes past the last slot are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                deadline_reg[i] <= DEADLINE_RST[i];
            end
        end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_SLOTS))) begin
            deadline_reg[cfg_index[TASK_W-1:0]] <= cfg_data;
        end
    end

    // remaining-deadline counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                remaining_reg[i] <= '0;
            end
        end else if (accept && s_tuser[0] == OP_RELEASE && rel_ok) begin
            remaining_reg[rel_task[IDX_W-1:0]] <= deadline_reg[rel_task];
        end else if (ctrl.scan_step && active) begin
            remaining_reg[scan_idx] <= dec_value;
        end
    end

    assign best_task = TASK_W'(best);
    // a release clears the scan unit too, so found stays low and no switch follows
    assign sw = found && (!cur_valid_reg || cur_task_reg != best_task);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            cur_task_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (ctrl.load_out) begin
                m_tvalid_reg <= 1'b1;
                if (sw) begin
                    cur_valid_reg <= 1'b1;
                    cur_task_reg  <= best_task;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_tdata_reg[7] <= 1'b0;
            if (sw) begin
                m_tdata_reg[1:0] <= best_task;
                m_tdata_reg[2]   <= 1'b1;
                m_tdata_reg[3]   <= 1'b1;
                m_tdata_reg[5:4] <= cur_valid_reg ? cur_task_reg : '0;
                m_tdata_reg[6]   <= cur_valid_reg;
            end else begin
                m_tdata_reg[1:0] <= cur_task_reg;
                m_tdata_reg[2]   <= cur_valid_reg;
                m_tdata_reg[3]   <= 1'b0;
                m_tdata_reg[5:4] <= '0;
                m_tdata_reg[6]   <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sim/edf_deadline_selector_top_tb.sv =====
// Self-checking bench for edf_deadline_selector_top: directed and random ticks and
// releases against an in-bench EDF predictor. Needs edf_pkg and the hdl sources.
`timescale 1ns / 1ps

module edf_deadline_selector_top_tb;
    import edf_pkg::*;

    localparam int NUM_TASKS   = NUM_TASKS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = NUM_TASKS + 4;

    // register map of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_T0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_T1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_T2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_T3 = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'd255;

    typedef struct packed {
        logic [TASK_W-1:0] chosen_task;
        logic              chosen_valid;
        logic              switched;
        logic [TASK_W-1:0] demoted_task;
        logic              demoted_valid;
    } choice_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [1:0] task_index, rest zero
    logic [0:0]           s_tuser;   // [0] operation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // [1:0] chosen, [2] valid, [3] switched, [5:4] demoted, [6] valid

    // predictor state
    cnt_t              deadline_cfg [NUM_SLOTS];
    cnt_t              ticks_left   [NUM_SLOTS];
    logic [TASK_W-1:0] running_task;
    logic              running_valid;

    choice_t pending_choices [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int cycle_count;
    int items_sent, ticks_sent, releases_sent, reg_writes;
    int results_seen, switches_seen, demotions_seen;

    edf_deadline_selector_top #(.NUM_TASKS(NUM_TASKS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_choices.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Release: reload the task's counter. Tick: age every live counter, pick the smallest, lowest index wins a tie.
    function automatic choice_t advance_schedule(input logic op, input logic [TASK_W-1:0] idx);
        choice_t           r;
        logic              found;
        logic [TASK_W-1:0] best;
        cnt_t              best_val;
        int                i;
        r        = '0;
        found    = 1'b0;
        best     = '0;
        best_val = '0;
        if (op == OP_RELEASE) begin
            if (idx < NUM_TASKS)
                ticks_left[idx] = deadline_cfg[idx];
        end else begin
            for (i = 0; i < NUM_TASKS; i++) begin
                if (ticks_left[i] != 0) begin
                    ticks_left[i] = ticks_left[i] - 1'b1;
                    if (!found || ticks_left[i] < best_val) begin
                        found    = 1'b1;
                        best     = i[TASK_W-1:0];
                        best_val = ticks_left[i];
                    end
                end
            end
            if (found && (!running_valid || running_task != best)) begin
                r.switched = 1'b1;
                if (running_valid) begin
                    r.demoted_valid = 1'b1;
                    r.demoted_task  = running_task;
                end
                running_task  = best;
                running_valid = 1'b1;
            end
        end
        r.chosen_task  = running_task;
        r.chosen_valid = running_valid;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH result %0d %s: got %0d want %0d",
                 $time, results_seen, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // receiver back-pressure
    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge aclk) begin
        choice_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_choices.size() == 0) begin
                report_mismatch("unexpected transaction, tdata", m_tdata, 0);
            end else begin
                want = pending_choices.pop_front();
                check_field("chosen_task",   m_tdata[1:0], want.chosen_task);
                check_field("chosen_valid",  m_tdata[2],   want.chosen_valid);
                check_field("switched",      m_tdata[3],   want.switched);
                check_field("demoted_task",  m_tdata[5:4], want.demoted_task);
                check_field("demoted_valid", m_tdata[6],   want.demoted_valid);
                switches_seen  += want.switched;
                demotions_seen += want.demoted_valid;
            end
            results_seen++;
        end
    end

    task automatic send_item(input logic op, input logic [TASK_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, idx};
        do @(posedge aclk); while (!s_tready);
        pending_choices.push_back(advance_schedule(op, idx));
        items_sent++;
        if (op == OP_RELEASE)
            releases_sent++;
        else
            ticks_sent++;
    endtask

    // Stop the stream and let every result come back before touching registers.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_choices.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_deadline(input logic [CFG_IDX_W-1:0] index, input cnt_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index < NUM_SLOTS)
            deadline_cfg[index] = value;
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_schedule();
        send_item(OP_TICK, 2'd0);     // nothing released yet
        send_item(OP_RELEASE, 2'd3);
        send_item(OP_TICK, 2'd1);     // first choice, no demotion
        send_item(OP_RELEASE, 2'd2);
        send_item(OP_TICK, 2'd2);     // task 2 overtakes task 3
        send_item(OP_RELEASE, 2'd1);
        send_item(OP_RELEASE, 2'd0);
        send_item(OP_TICK, 2'd3);
        send_item(OP_TICK, 2'd0);     // same pick, no switch
        send_item(OP_RELEASE, 2'd1);
        send_item(OP_TICK, 2'd0);
        wait_idle();
    endtask

    task automatic test_deadline_extremes();
        int n;
        write_deadline(REG_DEADLINE_T0, 8'd3);
        write_deadline(REG_DEADLINE_T1, 8'd3);
        write_deadline(REG_DEADLINE_T2, 8'd255);
        write_deadline(REG_DEADLINE_T3, 8'd0);    // zero deadline: never goes live
        write_deadline(REG_UNMAPPED_LO, 8'd7);    // ignored
        write_deadline(REG_UNMAPPED_HI, 8'd9);    // ignored
        send_item(OP_RELEASE, 2'd1);
        send_item(OP_RELEASE, 2'd0);
        send_item(OP_RELEASE, 2'd2);
        send_item(OP_RELEASE, 2'd3);
        for (n = 0; n < 4; n++)
            send_item(OP_TICK, 2'd0);             // tie goes to task 0, then expiry
        wait_idle();
        write_deadline(REG_DEADLINE_T1, 8'd1);
        write_deadline(REG_DEADLINE_T3, 8'd255);
        send_item(OP_RELEASE, 2'd1);
        send_item(OP_TICK, 2'd3);                 // task 1 reaches zero but is still picked
        send_item(OP_RELEASE, 2'd3);
        send_item(OP_TICK, 2'd0);
        send_item(OP_TICK, 2'd0);
        wait_idle();
    endtask

    task automatic load_random_deadlines();
        int   r;
        int   i;
        cnt_t v;
        for (i = 0; i < NUM_SLOTS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                v = cnt_t'($urandom_range(1, 12));
            else if (r < 80)
                v = 8'd255;
            else if (r < 85)
                v = 8'd0;
            else
                v = cnt_t'($urandom_range(1, 255));
            write_deadline(REG_DEADLINE_T0 + CFG_IDX_W'(i), v);
        end
        if ($urandom_range(0, 1))
            write_deadline(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                           cnt_t'($urandom));
    endtask

    // Mostly ticks with a steady trickle of releases so tasks come and go.
    task automatic test_random_traffic(input int n_items);
        int k;
        for (k = 0; k < n_items; k++) begin
            if (k % 80 == 79) begin
                wait_idle();
                load_random_deadlines();
            end
            if ($urandom_range(0, 99) < 35)
                send_item(OP_RELEASE, TASK_W'($urandom_range(0, 3)));
            else
                send_item(OP_TICK, TASK_W'($urandom_range(0, 3)));
        end
        wait_idle();
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_TICK;
        m_tready      = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 65;
        error_count   = 0;
        cycle_count   = 0;
        items_sent    = 0;
        ticks_sent    = 0;
        releases_sent = 0;
        reg_writes    = 0;
        results_seen  = 0;
        switches_seen = 0;
        demotions_seen = 0;
        deadline_cfg  = DEADLINE_RST;
        ticks_left    = '{default: '0};
        running_task  = '0;
        running_valid = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_schedule();
        test_deadline_extremes();

        load_random_deadlines();
        test_random_traffic(250);
        send_idle_pct = 65;
        recv_idle_pct = 6;
        load_random_deadlines();
        test_random_traffic(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random_deadlines();
        test_random_traffic(250);

        if (pending_choices.size() != 0)
            report_mismatch("results never returned", 0, pending_choices.size());

        $display("Ran %0d items (%0d ticks, %0d releases) and %0d register writes",
                 items_sent, ticks_sent, releases_sent, reg_writes);
        $display("Checked %0d results: %0d task switches, %0d with a demotion",
                 results_seen, switches_seen, demotions_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
